### rtl/swd_pkg.sv
// Shared types and constants for the serial wire debug host transfer engine.
package swd_pkg;

   localparam int DATA_BITS         = 32;
   localparam int RESET_HIGH_CLOCKS = 51;
   localparam int CNT_W             = 8;
   localparam int REQ_W             = 4;
   localparam int ACK_W             = 3;
   localparam int TURN_W            = 3;
   localparam int TRAIL_W           = 4;
   localparam int CSR_DATA_W        = 4;

   localparam logic [15:0] LINE_SEQ_A = 16'hE79E;
   localparam logic [15:0] LINE_SEQ_B = 16'h6DB7;

   localparam logic [TURN_W-1:0] TURN_MIN = 3'd1;
   localparam logic [TURN_W-1:0] TURN_MAX = 3'd4;

   localparam logic [TURN_W-1:0]  TURN_RESET  = 3'd1;
   localparam logic [TRAIL_W-1:0] TRAIL_RESET = 4'd3;

   // Configuration register indexes
   localparam logic CSR_TURNAROUND = 1'b0;
   localparam logic CSR_TRAILING   = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_REQ,
      PH_TURN,
      PH_ACK,
      PH_DATA,
      PH_DPAR,
      PH_TRAIL,
      PH_LRESET
   } phase_type;

   typedef struct packed {
      logic [TURN_W-1:0]  turn_cycles;   // already clamped to 1..4
      logic [TRAIL_W-1:0] trail_cycles;
   } swd_cfg_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] read_word;
      logic                 parity_error;
      logic [ACK_W-1:0]     ack_code;
      logic                 done_res;
      logic                 busy_res;
      logic                 clock_pulse;
      logic                 pin_drive;
      logic                 pin_out;
   } swd_result_type;

endpackage

### rtl/swd_host_transfer_engine_top.sv
// Serial wire debug host transfer engine: one request item per serial clock period,
// one result item back for each. Every accepted item produces its result in the
// output register on the next clock, and a new item is taken every cycle as long
// as the result side keeps up; a held result stalls the request side only while
// the output register is full and not being taken. A transfer sends the request,
// turns the line around and reads the ack; a good read adds data, parity and the
// trailing count. A line reset drives high, sequence A, high, sequence B, high,
// then low. Configuration writes take effect on the next clock and should only be
// issued while no operation is running.
module swd_host_transfer_engine_top
   import swd_pkg::*;
#(
   parameter int RESET_HIGH = RESET_HIGH_CLOCKS
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,  // start_req[0], request[4:1], pin_in[5], zero[7:6]
   input  logic                  req_tuser,  // mode[0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,  // pin_out[0], pin_drive[1], clock_pulse[2],
                                             // busy_res[3], ack_code[6:4], parity_error[7],
                                             // read_word[39:8]
   output logic                  rsp_tlast,  // done_res
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   swd_cfg_type    cfg;
   swd_result_type result, res_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           step;

   swd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   swd_core #(.RESET_HIGH(RESET_HIGH)) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .start_req (req_tdata[0]),
      .mode      (req_tuser),
      .request   (req_tdata[4:1]),
      .pin_in    (req_tdata[5]),
      .cfg       (cfg),
      .result    (result)
   );

   // Output register: load on each transfer in, drop once taken
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         res_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = res_ff.done_res;
   assign rsp_tdata  = {res_ff.read_word, res_ff.parity_error, res_ff.ack_code,
                        res_ff.busy_res, res_ff.clock_pulse, res_ff.pin_drive,
                        res_ff.pin_out};

endmodule

### rtl/swd_csr.sv
// Configuration registers: turnaround and trailing clock counts.
module swd_csr
   import swd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output swd_cfg_type           cfg
);

   logic [TURN_W-1:0]  turn_ff;
   logic [TRAIL_W-1:0] trail_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_ff  <= TURN_RESET;
         trail_ff <= TRAIL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TURNAROUND: turn_ff  <= csr_wdata[TURN_W-1:0];
            CSR_TRAILING:   trail_ff <= csr_wdata[TRAIL_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp turnaround into its legal range
   always_comb begin
      if (turn_ff < TURN_MIN) cfg.turn_cycles = TURN_MIN;
      else if (turn_ff > TURN_MAX) cfg.turn_cycles = TURN_MAX;
      else cfg.turn_cycles = turn_ff;
      cfg.trail_cycles = trail_ff;
   end

endmodule

### rtl/swd_core.sv
// Per-period protocol sequencer: phase state, bit counter, shift and ack capture.
module swd_core
   import swd_pkg::*;
#(
   parameter int RESET_HIGH = RESET_HIGH_CLOCKS
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic             start_req,
   input  logic             mode,
   input  logic [REQ_W-1:0] request,
   input  logic             pin_in,
   input  swd_cfg_type      cfg,
   output swd_result_type   result
);

   localparam logic [CNT_W-1:0] H       = CNT_W'(RESET_HIGH);
   localparam logic [CNT_W-1:0] SEQ_A_E = CNT_W'(RESET_HIGH + 16);
   localparam logic [CNT_W-1:0] HIGH2_E = CNT_W'(2 * RESET_HIGH + 16);
   localparam logic [CNT_W-1:0] SEQ_B_E = CNT_W'(2 * RESET_HIGH + 32);
   localparam logic [CNT_W-1:0] HIGH3_E = CNT_W'(3 * RESET_HIGH + 32);
   localparam logic [CNT_W-1:0] LR_LAST = CNT_W'(3 * RESET_HIGH + 47);
   localparam logic [CNT_W-1:0] DATA_N  = CNT_W'(DATA_BITS);

   phase_type            phase_ff, phase_in, cur_phase;
   logic [CNT_W-1:0]     cnt_ff, cnt_in, cur_cnt, cnt_inc;
   logic [DATA_BITS-1:0] shift_ff, shift_in, cur_shift;
   logic                 par_ff, par_in, cur_par;
   logic [ACK_W-1:0]     ack_ff, ack_in, cur_ack, ack_new;
   logic [REQ_W-1:0]     reqh_ff, reqh_in, cur_req;
   logic [3:0]           seq_ofs;
   logic                 lr_bit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         shift_ff <= '0;
         par_ff   <= 1'b0;
         ack_ff   <= '0;
         reqh_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         shift_ff <= shift_in;
         par_ff   <= par_in;
         ack_ff   <= ack_in;
         reqh_ff  <= reqh_in;
      end
   end

   // A start seen while idle loads fresh state and acts in the same period
   always_comb begin
      if (phase_ff == PH_IDLE && start_req) begin
         cur_phase = mode ? PH_LRESET : PH_REQ;
         cur_cnt   = '0;
         cur_shift = '0;
         cur_par   = 1'b0;
         cur_ack   = '0;
         cur_req   = request;
      end else begin
         cur_phase = phase_ff;
         cur_cnt   = cnt_ff;
         cur_shift = shift_ff;
         cur_par   = par_ff;
         cur_ack   = ack_ff;
         cur_req   = reqh_ff;
      end
   end

   assign cnt_inc = cur_cnt + CNT_W'(1);

   always_comb begin
      case (cur_cnt[1:0])
         2'd0:    ack_new = cur_ack | {2'b00, pin_in};
         2'd1:    ack_new = cur_ack | {1'b0, pin_in, 1'b0};
         2'd2:    ack_new = cur_ack | {pin_in, 2'b00};
         default: ack_new = cur_ack;
      endcase
   end

   // Line reset pattern: high, sequence A, high, sequence B, high, then low
   always_comb begin
      seq_ofs = '0;
      if (cur_cnt < H) begin
         lr_bit = 1'b1;
      end else if (cur_cnt < SEQ_A_E) begin
         seq_ofs = 4'(cur_cnt - H);
         lr_bit  = LINE_SEQ_A[seq_ofs];
      end else if (cur_cnt < HIGH2_E) begin
         lr_bit = 1'b1;
      end else if (cur_cnt < SEQ_B_E) begin
         seq_ofs = 4'(cur_cnt - HIGH2_E);
         lr_bit  = LINE_SEQ_B[seq_ofs];
      end else if (cur_cnt < HIGH3_E) begin
         lr_bit = 1'b1;
      end else begin
         lr_bit = 1'b0;
      end
   end

   always_comb begin
      phase_in = cur_phase;
      cnt_in   = cur_cnt;
      shift_in = cur_shift;
      par_in   = cur_par;
      ack_in   = cur_ack;
      reqh_in  = cur_req;
      result   = '0;
      result.busy_res    = (cur_phase != PH_IDLE);
      result.clock_pulse = (cur_phase != PH_IDLE);

      unique case (cur_phase)
         PH_REQ: begin
            result.pin_drive = 1'b1;
            case (cur_cnt[2:0])
               3'd0:    result.pin_out = 1'b1;
               3'd1:    result.pin_out = cur_req[0];
               3'd2:    result.pin_out = cur_req[1];
               3'd3:    result.pin_out = cur_req[2];
               3'd4:    result.pin_out = cur_req[3];
               3'd5:    result.pin_out = ^cur_req;
               3'd6:    result.pin_out = 1'b0;
               default: result.pin_out = 1'b1;
            endcase
            if (cur_cnt >= CNT_W'(7)) begin
               phase_in = PH_TURN;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         PH_TURN: begin
            cnt_in = cnt_inc;
            if (cnt_inc >= CNT_W'(cfg.turn_cycles)) begin
               phase_in = PH_ACK;
               cnt_in   = '0;
            end
         end
         PH_ACK: begin
            ack_in = ack_new;
            if (cur_cnt >= CNT_W'(2)) begin
               cnt_in = '0;
               if (ack_new == ACK_W'(1) && cur_req[1]) begin
                  phase_in = PH_DATA;
                  shift_in = '0;
                  par_in   = 1'b0;
               end else begin
                  phase_in        = PH_IDLE;
                  result.done_res = 1'b1;
                  result.ack_code = ack_new;
               end
            end else begin
               cnt_in = cnt_inc;
            end
         end
         PH_DATA: begin
            shift_in = {pin_in, cur_shift[DATA_BITS-1:1]};
            par_in   = cur_par ^ pin_in;
            cnt_in   = cnt_inc;
            if (cnt_inc >= DATA_N) begin
               phase_in = PH_DPAR;
               cnt_in   = '0;
            end
         end
         PH_DPAR: begin
            if (cur_par ^ pin_in) begin
               phase_in            = PH_IDLE;
               result.done_res     = 1'b1;
               result.ack_code     = cur_ack;
               result.parity_error = 1'b1;
            end else if (cfg.trail_cycles == '0) begin
               phase_in         = PH_IDLE;
               result.done_res  = 1'b1;
               result.ack_code  = cur_ack;
               result.read_word = cur_shift;
            end else begin
               phase_in = PH_TRAIL;
               cnt_in   = '0;
            end
         end
         PH_TRAIL: begin
            cnt_in = cnt_inc;
            if (cnt_inc >= CNT_W'(cfg.trail_cycles)) begin
               phase_in         = PH_IDLE;
               cnt_in           = '0;
               result.done_res  = 1'b1;
               result.ack_code  = cur_ack;
               result.read_word = cur_shift;
            end
         end
         PH_LRESET: begin
            result.pin_drive = 1'b1;
            result.pin_out   = lr_bit;
            if (cur_cnt >= LR_LAST) begin
               phase_in        = PH_IDLE;
               cnt_in          = '0;
               result.done_res = 1'b1;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

endmodule

### rtl/swd_checker.sv
// Port-level checks for the serial wire debug host transfer engine.
module swd_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Released pin is never driven high
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> !rsp_tdata[0])
      else $error("pin_out high while released");

   // Completion only inside an operation, with clock running
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[3] && rsp_tdata[2])
      else $error("done outside of busy period");

   // Parity error only on completion and with no read data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7] |-> rsp_tlast && rsp_tdata[39:8] == '0)
      else $error("parity error flagged outside completion");

   // Clock pulse and busy always agree
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2] == rsp_tdata[3])
      else $error("clock pulse and busy disagree");

endmodule

bind swd_host_transfer_engine_top swd_checker u_swd_checker (.*);

### tb/tb_swd_host_transfer_engine_top.sv
// Self-checking testbench for the serial wire debug host transfer engine.
module tb_swd_host_transfer_engine_top;
   import swd_pkg::*;

   typedef enum {ROW_IDLE, ROW_XFER, ROW_LRESET, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      logic [3:0]       rq;
      logic [2:0]       ack;
      logic [31:0]      data;
      logic             bad_par;
      logic             noisy;
      logic             csr_idx;
      logic [3:0]       csr_val;
      logic             typed;
      swd_result_type   want;
   } script_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;  // start_req[0], request[4:1], pin_in[5], zero[7:6]
   logic                  req_tuser  = 1'b0; // mode[0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [39:0]           rsp_tdata;  // pin_out[0], pin_drive[1], clock_pulse[2], busy_res[3],
                                      // ack_code[6:4], parity_error[7], read_word[39:8]
   logic                  rsp_tlast;  // done_res
   logic                  csr_we     = 1'b0;
   logic                  csr_index  = 1'b0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // engine shadow state
   phase_type          eng_phase;
   logic [CNT_W-1:0]   bit_cnt;
   logic [31:0]        shift_acc;
   logic               par_acc;
   logic [ACK_W-1:0]   ack_acc;
   logic [REQ_W-1:0]   req_held;
   logic [TURN_W-1:0]  cfg_turn;
   logic [TRAIL_W-1:0] cfg_trail;

   swd_result_type period_q[$];
   script_row_type script[$];
   int             error_count = 0;
   int             result_count = 0;
   int             burst_left = 0;
   int             op_items = 0;
   int             rx_cycle = 0;
   int             rx_mode = 0;

   swd_host_transfer_engine_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic log_mismatch(input string msg);
      $display("MISMATCH @%0t result %0d: %s", $time, result_count, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got)
         log_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
   endtask

   // One serial clock period of the engine.
   task automatic swd_period_predict(input logic start, input logic mode_bit,
                                     input logic [3:0] rq, input logic pin,
                                     output swd_result_type res);
      logic [TURN_W-1:0] ta;
      int                hi;
      hi = RESET_HIGH_CLOCKS;
      res = '0;
      ta = cfg_turn;
      if (ta < TURN_MIN) ta = TURN_MIN;
      if (ta > TURN_MAX) ta = TURN_MAX;

      if (eng_phase == PH_IDLE && start) begin
         req_held  = rq;
         bit_cnt   = '0;
         ack_acc   = '0;
         shift_acc = '0;
         par_acc   = 1'b0;
         eng_phase = mode_bit ? PH_LRESET : PH_REQ;
      end

      if (eng_phase != PH_IDLE) begin
         res.busy_res    = 1'b1;
         res.clock_pulse = 1'b1;
      end

      case (eng_phase)
         PH_REQ: begin
            res.pin_drive = 1'b1;
            case (bit_cnt[2:0])
               3'd0: res.pin_out = 1'b1;
               3'd1: res.pin_out = req_held[0];
               3'd2: res.pin_out = req_held[1];
               3'd3: res.pin_out = req_held[2];
               3'd4: res.pin_out = req_held[3];
               3'd5: res.pin_out = ^req_held;
               3'd6: res.pin_out = 1'b0;
               default: res.pin_out = 1'b1;
            endcase
            if (bit_cnt >= 7) begin
               eng_phase = PH_TURN;
               bit_cnt   = '0;
            end else bit_cnt++;
         end
         PH_TURN: begin
            bit_cnt++;
            if (bit_cnt >= ta) begin
               eng_phase = PH_ACK;
               bit_cnt   = '0;
            end
         end
         PH_ACK: begin
            ack_acc[bit_cnt[1:0]] = ack_acc[bit_cnt[1:0]] | pin;
            if (bit_cnt >= 2) begin
               bit_cnt = '0;
               if (ack_acc == 3'd1 && req_held[1]) begin
                  eng_phase = PH_DATA;
                  shift_acc = '0;
                  par_acc   = 1'b0;
               end else begin
                  eng_phase    = PH_IDLE;
                  res.done_res = 1'b1;
                  res.ack_code = ack_acc;
               end
            end else bit_cnt++;
         end
         PH_DATA: begin
            shift_acc = {pin, shift_acc[31:1]};
            par_acc   = par_acc ^ pin;
            bit_cnt++;
            if (bit_cnt >= DATA_BITS) begin
               eng_phase = PH_DPAR;
               bit_cnt   = '0;
            end
         end
         PH_DPAR: begin
            if (par_acc ^ pin) begin
               eng_phase        = PH_IDLE;
               res.done_res     = 1'b1;
               res.ack_code     = ack_acc;
               res.parity_error = 1'b1;
            end else if (cfg_trail == 0) begin
               eng_phase     = PH_IDLE;
               res.done_res  = 1'b1;
               res.ack_code  = ack_acc;
               res.read_word = shift_acc;
            end else begin
               eng_phase = PH_TRAIL;
               bit_cnt   = '0;
            end
         end
         PH_TRAIL: begin
            bit_cnt++;
            if (bit_cnt >= cfg_trail) begin
               eng_phase     = PH_IDLE;
               bit_cnt       = '0;
               res.done_res  = 1'b1;
               res.ack_code  = ack_acc;
               res.read_word = shift_acc;
            end
         end
         PH_LRESET: begin
            res.pin_drive = 1'b1;
            if (bit_cnt < hi) res.pin_out = 1'b1;
            else if (bit_cnt < hi + 16) res.pin_out = LINE_SEQ_A[bit_cnt - hi];
            else if (bit_cnt < 2 * hi + 16) res.pin_out = 1'b1;
            else if (bit_cnt < 2 * hi + 32) res.pin_out = LINE_SEQ_B[bit_cnt - (2 * hi + 16)];
            else if (bit_cnt < 3 * hi + 32) res.pin_out = 1'b1;
            else res.pin_out = 1'b0;
            if (bit_cnt >= 3 * hi + 47) begin
               eng_phase    = PH_IDLE;
               bit_cnt      = '0;
               res.done_res = 1'b1;
            end else bit_cnt++;
         end
         default: eng_phase = PH_IDLE;
      endcase
   endtask

   // Drive one period item, wait for its transfer, then queue its expected result.
   task automatic send_item(input logic start, input logic mode_bit, input logic [3:0] rq,
                            input logic pin, input logic typed, input swd_result_type want);
      int             gap;
      swd_result_type res;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 24);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, pin, rq, start};
      req_tuser  <= mode_bit;
      do @(posedge clock); while (!req_tready);
      swd_period_predict(start, mode_bit, rq, pin, res);
      // a typed expectation stands for the period that ends the operation
      if (typed && eng_phase == PH_IDLE) res = want;
      period_q.push_back(res);
   endtask

   // Run one operation to completion, feeding ack, data and parity on the pin.
   task automatic run_op(input logic mode_bit, input logic [3:0] rq, input logic [2:0] ack,
                         input logic [31:0] data, input logic bad_par, input logic noisy,
                         input logic typed, input swd_result_type want);
      logic pin;
      send_item(1'b1, mode_bit, rq, 1'($urandom_range(0, 1)), typed, want);
      op_items++;
      while (eng_phase != PH_IDLE) begin
         case (eng_phase)
            PH_ACK:  pin = ack[bit_cnt[1:0]];
            PH_DATA: pin = data[bit_cnt[4:0]];
            PH_DPAR: pin = ^data ^ bad_par;
            default: pin = 1'($urandom_range(0, 1));
         endcase
         // start pulses while busy must be ignored
         send_item(noisy ? 1'($urandom_range(0, 1)) : 1'b0, 1'($urandom_range(0, 1)),
                   4'($urandom_range(0, 15)), pin, typed, want);
         op_items++;
      end
   endtask

   // Hold the sender until every expected result has been taken.
   task automatic settle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (period_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [3:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_TURNAROUND) cfg_turn = val[TURN_W-1:0];
      else cfg_trail = val;
      @(posedge clock);
   endtask

   task automatic retune();
      logic [3:0] tv, rv;
      case ($urandom_range(0, 5))
         0: tv = 4'd0;
         1: tv = 4'd1;
         2: tv = 4'd4;
         3: tv = 4'hF;
         default: tv = 4'($urandom_range(0, 15));
      endcase
      case ($urandom_range(0, 3))
         0: rv = 4'd0;
         1: rv = 4'd15;
         default: rv = 4'($urandom_range(0, 15));
      endcase
      settle();
      write_csr(CSR_TURNAROUND, tv);
      write_csr(CSR_TRAILING, rv);
   endtask

   task automatic random_op();
      logic [3:0]  rq;
      logic [2:0]  ack;
      logic [31:0] data;
      int          pick;
      rq = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 3) != 0) rq[1] = 1'b1;   // mostly reads
      pick = $urandom_range(0, 9);
      case (pick)
         7: ack = 3'd2;
         8: ack = 3'd4;
         9: ack = 3'($urandom_range(0, 7));
         default: ack = 3'd1;
      endcase
      case ($urandom_range(0, 15))
         0: data = '0;
         1: data = '1;
         default: data = $urandom;
      endcase
      run_op($urandom_range(0, 31) == 0, rq, ack, data, $urandom_range(0, 9) == 0,
             $urandom_range(0, 4) == 0, 1'b0, '0);
   endtask

   function automatic swd_result_type done_period(input logic [2:0] ack, input logic perr,
                                                  input logic [31:0] word);
      swd_result_type r;
      r = '0;
      r.clock_pulse  = 1'b1;
      r.busy_res     = 1'b1;
      r.done_res     = 1'b1;
      r.ack_code     = ack;
      r.parity_error = perr;
      r.read_word    = word;
      return r;
   endfunction

   function automatic script_row_type op_row(input row_kind_type kind, input logic [3:0] rq,
                                             input logic [2:0] ack, input logic [31:0] data,
                                             input logic bad_par, input logic noisy,
                                             input logic typed, input swd_result_type want);
      script_row_type r;
      r.kind    = kind;
      r.rq      = rq;
      r.ack     = ack;
      r.data    = data;
      r.bad_par = bad_par;
      r.noisy   = noisy;
      r.csr_idx = CSR_TURNAROUND;
      r.csr_val = '0;
      r.typed   = typed;
      r.want    = want;
      return r;
   endfunction

   function automatic script_row_type csr_row(input logic idx, input logic [3:0] val);
      script_row_type r;
      r = op_row(ROW_CSR, '0, '0, '0, 1'b0, 1'b0, 1'b0, '0);
      r.csr_idx = idx;
      r.csr_val = val;
      return r;
   endfunction

   // receiver: applies one of four stall patterns, re-picked at random
   always @(posedge clock) begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (rx_cycle % 4) != 0;
         default: rsp_tready <= $urandom_range(0, 4) == 0;
      endcase
   end

   always @(posedge clock) begin
      swd_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pin_out      = rsp_tdata[0];
         got.pin_drive    = rsp_tdata[1];
         got.clock_pulse  = rsp_tdata[2];
         got.busy_res     = rsp_tdata[3];
         got.ack_code     = rsp_tdata[6:4];
         got.parity_error = rsp_tdata[7];
         got.read_word    = rsp_tdata[39:8];
         got.done_res     = rsp_tlast;
         if (period_q.size() == 0) begin
            log_mismatch("result transfer with nothing expected");
         end else begin
            want = period_q.pop_front();
            check_field("pin_out", 32'(want.pin_out), 32'(got.pin_out));
            check_field("pin_drive", 32'(want.pin_drive), 32'(got.pin_drive));
            check_field("clock_pulse", 32'(want.clock_pulse), 32'(got.clock_pulse));
            check_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
            check_field("done_res", 32'(want.done_res), 32'(got.done_res));
            check_field("ack_code", 32'(want.ack_code), 32'(got.ack_code));
            check_field("parity_error", 32'(want.parity_error), 32'(got.parity_error));
            check_field("read_word", want.read_word, got.read_word);
         end
         result_count++;
      end
   end

   initial begin
      int next_cfg;
      eng_phase = PH_IDLE;
      bit_cnt   = '0;
      shift_acc = '0;
      par_acc   = 1'b0;
      ack_acc   = '0;
      req_held  = '0;
      cfg_turn  = TURN_RESET;
      cfg_trail = TRAIL_RESET;

      script.push_back(op_row(ROW_IDLE, 4'hF, 0, 0, 0, 0, 1, '0));
      script.push_back(op_row(ROW_XFER, 4'b0010, 1, 32'h0, 0, 0, 1, done_period(1, 0, 32'h0)));
      script.push_back(op_row(ROW_XFER, 4'b1111, 1, 32'hFFFF_FFFF, 0, 0, 1,
                              done_period(1, 0, 32'hFFFF_FFFF)));
      script.push_back(op_row(ROW_XFER, 4'b1011, 1, 32'hA5A5_5A5A, 1, 0, 1,
                              done_period(1, 1, 32'h0)));
      script.push_back(op_row(ROW_XFER, 4'b1101, 1, 32'h0, 0, 0, 1, done_period(1, 0, 32'h0)));
      script.push_back(op_row(ROW_XFER, 4'b0110, 2, 32'h0, 0, 0, 1, done_period(2, 0, 32'h0)));
      script.push_back(op_row(ROW_XFER, 4'b0111, 4, 32'h0, 0, 0, 1, done_period(4, 0, 32'h0)));
      script.push_back(op_row(ROW_XFER, 4'b1010, 7, 32'h0, 0, 0, 1, done_period(7, 0, 32'h0)));
      script.push_back(op_row(ROW_XFER, 4'b0011, 0, 32'h0, 0, 0, 1, done_period(0, 0, 32'h0)));
      script.push_back(op_row(ROW_XFER, 4'b0000, 2, 32'h0, 0, 0, 1, done_period(2, 0, 32'h0)));
      script.push_back(csr_row(CSR_TURNAROUND, 4'd0));
      script.push_back(op_row(ROW_XFER, 4'b0110, 1, 32'h8000_0001, 0, 0, 0, '0));
      script.push_back(csr_row(CSR_TRAILING, 4'd0));
      script.push_back(op_row(ROW_XFER, 4'b1110, 1, 32'h1234_5678, 0, 0, 1,
                              done_period(1, 0, 32'h1234_5678)));
      script.push_back(op_row(ROW_XFER, 4'b1110, 1, 32'h0F0F_0F0F, 1, 0, 1,
                              done_period(1, 1, 32'h0)));
      script.push_back(csr_row(CSR_TURNAROUND, 4'hF));
      script.push_back(op_row(ROW_XFER, 4'b0010, 1, 32'hDEAD_BEEF, 0, 1, 0, '0));
      script.push_back(csr_row(CSR_TURNAROUND, 4'd4));
      script.push_back(csr_row(CSR_TRAILING, 4'd15));
      script.push_back(op_row(ROW_XFER, 4'b1111, 1, 32'h7FFF_FFFE, 0, 1, 0, '0));
      script.push_back(op_row(ROW_LRESET, 4'h0, 0, 32'h0, 0, 1, 0, '0));
      script.push_back(csr_row(CSR_TURNAROUND, 4'd2));
      script.push_back(csr_row(CSR_TRAILING, 4'd1));
      script.push_back(op_row(ROW_XFER, 4'b0110, 1, 32'hC3C3_3C3C, 0, 0, 0, '0));
      script.push_back(op_row(ROW_IDLE, 4'h0, 0, 0, 0, 0, 1, '0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         case (script[i].kind)
            ROW_IDLE:
               send_item(1'b0, 1'($urandom_range(0, 1)), script[i].rq,
                         1'($urandom_range(0, 1)), script[i].typed, script[i].want);
            ROW_CSR: begin
               settle();
               write_csr(script[i].csr_idx, script[i].csr_val);
            end
            default:
               run_op(script[i].kind == ROW_LRESET, script[i].rq, script[i].ack,
                      script[i].data, script[i].bad_par, script[i].noisy,
                      script[i].typed, script[i].want);
         endcase
      end

      // random operations fill up the item budget left after the table
      next_cfg = 150;
      while (op_items < 950) begin
         if (op_items >= next_cfg) begin
            retune();
            next_cfg = op_items + $urandom_range(120, 220);
         end
         // idle periods between operations
         repeat ($urandom_range(0, 2))
            send_item(1'b0, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)), 1'b0, '0);
         random_op();
      end

      settle();
      repeat (5) @(posedge clock);
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
